FILE: rtl/lmtf_pkg.sv
// shared constants and types for the lru move-to-front list
package lmtf_pkg;

	localparam int DEPTH    = 16;
	localparam int KEY_BITS = 32;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// port field widths
	localparam int KEY_OUT_W = 32;
	localparam int POS_W     = 4;
	localparam int OCC_W     = 5;
	localparam int CAP_W     = 5;
	localparam int S_DATA_W  = 32;
	localparam int M_DATA_W  = 48;

	// request and result kinds
	localparam logic REQ_ACCESS  = 1'b0;
	localparam logic REQ_DUMP    = 1'b1;
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_ENTRY  = 1'b1;

	typedef logic [KEY_BITS-1:0] key_t;

	// per-cell control from the list controller
	typedef struct packed {
		logic shift;   // load the neighbor's key this cycle
		logic live;    // entry index below the fill count
		logic rd_sel;  // drive this entry onto the read chain
	} lmtf_cell_ctl_t;

endpackage

FILE: rtl/lmtf_cell.sv
// one list entry: key register, compare, and prefix/read chain links
module lmtf_cell
	import lmtf_pkg::*;
(
	input  logic           clk,
	input  lmtf_cell_ctl_t ctl,
	input  key_t           key_prev,   // key of the neighbor in front
	input  key_t           key_cmp,    // key being looked up
	input  logic           seen_in,    // a match exists in front of this cell
	input  key_t           rd_in,
	output key_t           key_here,
	output logic           seen_out,
	output logic           first,      // first live match along the list
	output key_t           rd_out
);

	key_t key_q;
	logic match;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= key_prev;
		end
	end

	assign match    = ctl.live && (key_q == key_cmp);
	assign first    = match && !seen_in;
	assign seen_out = seen_in || match;
	assign key_here = key_q;
	assign rd_out   = rd_in | (ctl.rd_sel ? key_q : '0);

endmodule

FILE: rtl/lru_move_to_front_list_top.sv
// lru move-to-front list: chain of entry cells plus access/dump controller
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tuser = req_type, s_tdata = key_in
// m_*       out  m_tvalid/m_tready  m_tuser = result_kind, m_tdata = report/entry,
//                                   m_tlast = last
// cfg_*     in   cfg_wr_en          cfg_wr_data = capacity
//
// in an access all cells compare in parallel, the first-match
// chain finds the hit, and the cells in front shift back in the same edge
// a dump walks the entries from the head off the cell read chain, one each time
// the output is free (an empty list gives one invalid entry); input waits meanwhile
// one output register parts the sides; a stalled result holds it and input waits
// reset clears the fill count and sets full capacity; entries are never read unwritten
module lru_move_to_front_list_top
	import lmtf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// config
	input  logic                cfg_wr_en,
	input  logic [CAP_W-1:0]    cfg_wr_data,   // capacity
	// request stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,       // [31:0] key_in
	input  logic                s_tuser,       // [0] req_type
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	// [31:0] key_out, [32] hit, [33] evicted, [37:34] position,
	// [42:38] occupancy, [43] entry_valid, [47:44] zero
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser,       // [0] result_kind
	output logic                m_tlast        // last
);

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cap_q;
	logic [IDX_W-1:0] dump_idx_q;

	logic             m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic             m_tuser_q;
	logic             m_tlast_q;

	// cell chain wiring
	lmtf_cell_ctl_t   cell_ctl [DEPTH];
	key_t             cell_key [DEPTH];
	logic [DEPTH:0]   seen;
	logic [DEPTH-1:0] first;
	key_t             rd_chain [DEPTH+1];

	key_t             key_in;
	logic             out_free;
	logic             in_xfer;
	logic             is_access;
	logic             hit;
	logic             full;
	logic [CNT_W-1:0] shift_lim;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] found_idx;
	logic [IDX_W-1:0] last_idx;
	key_t             rd_key;
	logic [CNT_W-1:0] cap_wr;

	assign key_in    = KEY_BITS'(s_tdata[S_DATA_W-1:0]);
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign in_xfer   = s_tvalid && s_tready;
	assign is_access = in_xfer && (s_tuser == REQ_ACCESS);

	assign full      = count_q >= cap_q;
	// on a miss cells below this limit shift back
	assign shift_lim = full ? cap_q : count_q + CNT_W'(1);
	assign hit       = seen[DEPTH];
	assign last_idx  = IDX_W'(count_q - CNT_W'(1));
	// eviction reads the tail at capacity-1, a dump walks from the head
	assign rd_idx    = (state_q == ST_DUMP) ? dump_idx_q : IDX_W'(cap_q - CNT_W'(1));
	assign rd_key    = rd_chain[DEPTH];

	assign seen[0]     = 1'b0;
	assign rd_chain[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		key_t prev_key;

		assign prev_key = (i == 0) ? key_in : cell_key[(i == 0) ? 0 : i - 1];

		always_comb begin
			cell_ctl[i].live   = CNT_W'(i) < count_q;
			cell_ctl[i].rd_sel = rd_idx == IDX_W'(i);
			// hit: head through the hit entry; miss: up to the limit
			cell_ctl[i].shift  = is_access &&
				(hit ? !seen[i] : (CNT_W'(i) < shift_lim));
		end

		lmtf_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl[i]),
			.key_prev (prev_key),
			.key_cmp  (key_in),
			.seen_in  (seen[i]),
			.rd_in    (rd_chain[i]),
			.key_here (cell_key[i]),
			.seen_out (seen[i+1]),
			.first    (first[i]),
			.rd_out   (rd_chain[i+1])
		);
	end

	// index of the single first match
	always_comb begin
		found_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			found_idx = found_idx | (first[i] ? IDX_W'(i) : '0);
		end
	end

	// capacity write clamped to 1..DEPTH
	always_comb begin
		if (cfg_wr_data == '0) begin
			cap_wr = CNT_W'(1);
		end else if (32'(cfg_wr_data) > 32'(DEPTH)) begin
			cap_wr = CNT_W'(DEPTH);
		end else begin
			cap_wr = CNT_W'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			cap_q      <= CNT_W'(DEPTH);
			dump_idx_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cap_wr;
				if (count_q > cap_wr) begin
					count_q <= cap_wr;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						m_tlast_q  <= 1'b1;
						if (s_tuser == REQ_ACCESS) begin
							m_tvalid_q <= 1'b1;
							m_tuser_q  <= KIND_REPORT;
							if (hit) begin
								m_tdata_q <= M_DATA_W'({1'b1, OCC_W'(count_q),
									POS_W'(found_idx), 1'b0, 1'b1, KEY_OUT_W'(0)});
							end else if (full) begin
								m_tdata_q <= M_DATA_W'({1'b1, OCC_W'(count_q),
									POS_W'(0), 1'b1, 1'b0, KEY_OUT_W'(rd_key)});
							end else begin
								count_q   <= count_q + CNT_W'(1);
								m_tdata_q <= M_DATA_W'({1'b1,
									OCC_W'(count_q + CNT_W'(1)),
									POS_W'(0), 1'b0, 1'b0, KEY_OUT_W'(0)});
							end
						end else begin
							m_tuser_q <= KIND_ENTRY;
							if (count_q == '0) begin
								// empty list: one invalid entry
								m_tvalid_q <= 1'b1;
								m_tdata_q  <= '0;
							end else begin
								m_tvalid_q <= 1'b0;
								dump_idx_q <= '0;
								state_q    <= ST_DUMP;
							end
						end
					end else if (m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= KIND_ENTRY;
						m_tlast_q  <= dump_idx_q == last_idx;
						m_tdata_q  <= M_DATA_W'({1'b1, OCC_W'(count_q),
							POS_W'(dump_idx_q), 1'b0, 1'b0, KEY_OUT_W'(rd_key)});
						dump_idx_q <= dump_idx_q + IDX_W'(1);
						if (dump_idx_q == last_idx) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
